FILE: sv/collider_pair_overlap_test_core_defines.svh
// ----------------------------------------------------------------------------
// Collider pair overlap test assertion macros
// Shared concurrent assertion forms for the overlap test core.
// ----------------------------------------------------------------------------
`ifndef COLLIDER_PAIR_OVERLAP_TEST_CORE_DEFINES_SVH
`define COLLIDER_PAIR_OVERLAP_TEST_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPO_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cpo_pkg.sv
// ----------------------------------------------------------------------------
// Collider pair overlap test package
// Field widths, derived arithmetic widths, codes and types of the core.
// ----------------------------------------------------------------------------
package cpo_pkg;

    localparam int POS_WIDTH   = 24;
    localparam int EXT_WIDTH   = 16;
    localparam int SCALE_WIDTH = 12;

    // Scale has eight fraction bits; positions and extents move to 2^-8 units.
    localparam int FRAC_SHIFT = 8;

    localparam int H_W    = EXT_WIDTH + SCALE_WIDTH;
    localparam int LIM_W  = EXT_WIDTH + FRAC_SHIFT;
    localparam int D_W    = LIM_W + 1;
    localparam int MUL_W  = (H_W > D_W) ? H_W : D_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int LSQ_W  = 2 * LIM_W;
    localparam int ACC_W  = 2 * D_W;
    localparam int SB_W   = ((POS_WIDTH + FRAC_SHIFT > H_W + 1) ?
                             (POS_WIDTH + FRAC_SHIFT) : (H_W + 1)) + 2;

    localparam int IN_FIELDS_W = 3 * (POS_WIDTH + EXT_WIDTH + SCALE_WIDTH);
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 8;
    localparam int OUT_USER_W  = 2;

    localparam int USER_KIND    = 0;
    localparam int USER_PRESENT = 1;
    localparam int USER_IS_BOX  = 2;

    localparam logic [1:0] PK_SPHERES = 2'd0;
    localparam logic [1:0] PK_BOXES   = 2'd1;
    localparam logic [1:0] PK_MIXED   = 2'd2;
    localparam logic [1:0] PK_SKIP    = 2'd3;

    typedef logic [POS_WIDTH-1:0]   pos_t;
    typedef logic [EXT_WIDTH-1:0]   ext_t;
    typedef logic [SCALE_WIDTH-1:0] scale_t;

    typedef struct packed {
        logic           present;
        logic           is_box;
        pos_t   [2:0]   pos;
        ext_t   [2:0]   ext;
        scale_t [2:0]   scl;
    } obj_t;

endpackage

FILE: sv/cpo_mul.sv
// ----------------------------------------------------------------------------
// Collider pair overlap test multiplier
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module cpo_mul
    import cpo_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic [PROD_W-1:0] p
);

    always_ff @(posedge clk)
    begin
        p <= PROD_W'(a) * PROD_W'(b);
    end

endmodule

FILE: sv/collider_pair_overlap_test_core.sv
// ----------------------------------------------------------------------------
// Collider pair overlap test core
// Sphere and axis-aligned box overlap test between a stored and a new object.
//
// Channel  Dir  Word contents
// s_*      in   tdata: pos_x,pos_y,pos_z,ext_x,ext_y,ext_z,scale_x,scale_y,scale_z
//               tuser: kind, present, is_box
// m_*      out  tdata: hit; tuser: pair_kind
//
// A store word (kind 0) leaves the core idle, so it is ready again in the next cycle.
// A test word (kind 1) runs eleven steps on the shared multiplier and distance logic,
// then loads the output register once it is free; ready stays low until then, so no
// new word is accepted while a test is in progress.
// The result waits in the output register while the next word is accepted.
// Reset is asynchronous, active low, and clears the stored object.
// ----------------------------------------------------------------------------
`include "collider_pair_overlap_test_core_defines.svh"

module collider_pair_overlap_test_core
    import cpo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_x, pos_y, pos_z, ext_x, ext_y, ext_z, scale_x, scale_y, scale_z
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind, present, is_box
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hit
    output logic [OUT_DATA_W-1:0] m_tdata,
    // pair_kind
    output logic [OUT_USER_W-1:0] m_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_D0   = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_LIM  = STEP_W'(6);
    localparam logic [STEP_W-1:0] STEP_SQ0  = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(10);

    localparam logic signed [SB_W-1:0] D_CAP = SB_W'(64'd1 << (D_W - 1));

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              hit_out_reg;
    logic [1:0]        pk_out_reg;

    obj_t in_obj;
    obj_t held_reg;
    obj_t cur_reg;
    obj_t bx_obj;
    obj_t sp_obj;

    logic [H_W-1:0]   h_reg [3];
    logic [D_W-1:0]   d_reg [3];
    logic [LSQ_W-1:0] lim_sq_reg;
    logic [ACC_W-1:0] acc_reg;
    logic             box_ok_reg;

    logic [1:0]        pk;
    logic [1:0]        axis;
    logic [1:0]        h_idx;
    logic [LIM_W-1:0]  lim;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;
    logic              hit_calc;
    logic              in_accept;
    logic              box_fail;
    logic [D_W-1:0]    dist_sat;

    logic signed [SB_W-1:0] hp, cp, diff, mag, lim_box;
    logic signed [SB_W-1:0] sc, bc, hh, lo, hi, sb, dist_raw;

    always_comb
    begin
        in_obj.present = s_tuser[USER_PRESENT];
        in_obj.is_box  = s_tuser[USER_IS_BOX];
        for (int a = 0; a < 3; a++)
        begin
            in_obj.pos[a] = s_tdata[a*POS_WIDTH +: POS_WIDTH];
            in_obj.ext[a] = s_tdata[3*POS_WIDTH + a*EXT_WIDTH +: EXT_WIDTH];
            in_obj.scl[a] = s_tdata[3*(POS_WIDTH+EXT_WIDTH) + a*SCALE_WIDTH +: SCALE_WIDTH];
        end
    end

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb
    begin
        if (!held_reg.present || !cur_reg.present)
            pk = PK_SKIP;
        else if (!held_reg.is_box && !cur_reg.is_box)
            pk = PK_SPHERES;
        else if (held_reg.is_box && cur_reg.is_box)
            pk = PK_BOXES;
        else
            pk = PK_MIXED;
    end

    assign bx_obj = held_reg.is_box ? held_reg : cur_reg;
    assign sp_obj = held_reg.is_box ? cur_reg : held_reg;

    always_comb
    begin
        if (step_reg < STEP_D0)
            axis = step_reg[1:0];
        else if (step_reg < STEP_LIM)
            axis = 2'(step_reg - STEP_D0);
        else if (step_reg >= STEP_SQ0 && step_reg <= STEP_LAST - STEP_W'(1))
            axis = 2'(step_reg - STEP_SQ0);
        else
            axis = 2'd0;
    end

    assign h_idx = 2'(step_reg - STEP_W'(1));

    always_comb
    begin
        if (pk == PK_MIXED)
            lim = LIM_W'(sp_obj.ext[0]) << FRAC_SHIFT;
        else
            lim = LIM_W'(held_reg.ext[0]) + LIM_W'(cur_reg.ext[0]);
    end

    always_comb
    begin
        hp      = SB_W'($signed(held_reg.pos[axis]));
        cp      = SB_W'($signed(cur_reg.pos[axis]));
        diff    = hp - cp;
        mag     = (diff < 0) ? -diff : diff;
        lim_box = $signed(SB_W'(held_reg.ext[axis])) + $signed(SB_W'(cur_reg.ext[axis]));
        box_fail = (mag > lim_box);

        sc = SB_W'($signed(sp_obj.pos[axis])) <<< FRAC_SHIFT;
        bc = SB_W'($signed(bx_obj.pos[axis])) <<< FRAC_SHIFT;
        hh = $signed(SB_W'(h_reg[axis]));
        lo = bc - hh;
        hi = bc + hh;
        if (sc > hi)
            sb = sc - hi;
        else if (sc < lo)
            sb = lo - sc;
        else
            sb = '0;

        dist_raw = (pk == PK_MIXED) ? sb : mag;
        dist_sat = (dist_raw >= D_CAP) ? D_W'(D_CAP) : dist_raw[D_W-1:0];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_RUN)
        begin
            if (step_reg < STEP_D0)
            begin
                mul_a = MUL_W'(bx_obj.ext[axis]);
                mul_b = MUL_W'(bx_obj.scl[axis]);
            end
            else if (step_reg == STEP_LIM)
            begin
                mul_a = MUL_W'(lim);
                mul_b = MUL_W'(lim);
            end
            else if (step_reg >= STEP_SQ0 && step_reg < STEP_LAST)
            begin
                mul_a = MUL_W'(d_reg[axis]);
                mul_b = MUL_W'(d_reg[axis]);
            end
        end
    end

    cpo_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    always_comb
    begin
        case (pk)
            PK_SKIP:  hit_calc = 1'b0;
            PK_BOXES: hit_calc = box_ok_reg;
            default:  hit_calc = (acc_reg <= ACC_W'(lim_sq_reg));
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_accept && s_tuser[USER_KIND])
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            held_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
            if (in_accept && !s_tuser[USER_KIND])
                held_reg <= in_obj;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && s_tuser[USER_KIND])
        begin
            cur_reg    <= in_obj;
            box_ok_reg <= 1'b1;
        end
        if (state_reg == ST_RUN)
        begin
            if (step_reg >= STEP_W'(1) && step_reg <= STEP_D0)
                h_reg[h_idx] <= prod[H_W-1:0];
            if (step_reg >= STEP_D0 && step_reg < STEP_LIM)
            begin
                d_reg[axis] <= dist_sat;
                if (box_fail)
                    box_ok_reg <= 1'b0;
            end
            if (step_reg == STEP_SQ0)
                lim_sq_reg <= prod[LSQ_W-1:0];
            if (step_reg == STEP_SQ0 + STEP_W'(1))
                acc_reg <= prod[ACC_W-1:0];
            else if (step_reg > STEP_SQ0 + STEP_W'(1))
                acc_reg <= acc_reg + prod[ACC_W-1:0];
        end
        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
        begin
            hit_out_reg <= hit_calc;
            pk_out_reg  <= pk;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(hit_out_reg);
    assign m_tuser  = pk_out_reg;

    `CPO_ASSERT_NEXT(a_test_busy, in_accept && s_tuser[USER_KIND], !s_tready, "test word did not start the sequencer")
    `CPO_ASSERT_NEXT(a_result_load, (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready), m_tvalid && s_tready, "result not loaded when output was free")
    `CPO_ASSERT_SAME(a_skip_no_hit, m_tvalid && (m_tuser == PK_SKIP), !m_tdata[0], "skipped pair reported a hit")
    `CPO_ASSERT_SAME(a_step_range, state_reg == ST_RUN, step_reg <= STEP_LAST, "step counter past last step")

endmodule

FILE: tb/overlap_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Overlap result checker
// Watches the input and result channels of the overlap test core. It keeps its
// own copy of the stored object, works out hit and pair kind for every test
// word, and compares each result word with the oldest pending prediction.
// ----------------------------------------------------------------------------
module overlap_result_checker
    import cpo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [OUT_USER_W-1:0] m_tuser,
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        logic       hit;
        logic [1:0] pair_kind;
    } overlap_t;

    obj_t     held_obj;
    overlap_t predicted_q[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report(input string msg);
        mismatches++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // Sum of three squared distances against a squared limit, all exact.
    function automatic bit within_reach(input logic [63:0] d0, input logic [63:0] d1,
                                        input logic [63:0] d2, input logic [63:0] lim);
        logic [127:0] acc;
        acc = 128'(d0) * 128'(d0) + 128'(d1) * 128'(d1) + 128'(d2) * 128'(d2);
        return acc <= 128'(lim) * 128'(lim);
    endfunction

    function automatic overlap_t predict_overlap(input obj_t first, input obj_t second);
        overlap_t    r;
        obj_t        sph;
        obj_t        box;
        logic [63:0] d [0:2];
        longint      a;
        longint      b;
        longint      half;
        r = '0;
        if (!first.present || !second.present)
        begin
            r.pair_kind = PK_SKIP;
        end
        else if (!first.is_box && !second.is_box)
        begin
            r.pair_kind = PK_SPHERES;
            for (int i = 0; i < 3; i++)
            begin
                a = $signed(first.pos[i]);
                b = $signed(second.pos[i]);
                d[i] = (a >= b) ? a - b : b - a;
            end
            r.hit = within_reach(d[0], d[1], d[2], 64'(first.ext[0]) + 64'(second.ext[0]));
        end
        else if (first.is_box && second.is_box)
        begin
            r.pair_kind = PK_BOXES;
            r.hit = 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                a = $signed(first.pos[i]);
                b = $signed(second.pos[i]);
                if (((a >= b) ? a - b : b - a) > longint'(first.ext[i]) + longint'(second.ext[i]))
                    r.hit = 1'b0;
            end
        end
        else
        begin
            r.pair_kind = PK_MIXED;
            if (first.is_box)
            begin
                box = first;
                sph = second;
            end
            else
            begin
                box = second;
                sph = first;
            end
            // Clamp the sphere center into the scaled box, in units of 2^-8.
            for (int i = 0; i < 3; i++)
            begin
                a    = longint'($signed(sph.pos[i])) <<< FRAC_SHIFT;
                b    = longint'($signed(box.pos[i])) <<< FRAC_SHIFT;
                half = longint'(box.ext[i]) * longint'(box.scl[i]);
                if (a > b + half)
                    d[i] = a - (b + half);
                else if (a < b - half)
                    d[i] = (b - half) - a;
                else
                    d[i] = '0;
            end
            r.hit = within_reach(d[0], d[1], d[2], 64'(sph.ext[0]) << FRAC_SHIFT);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        overlap_t want;
        obj_t     word;
        if (!rst_n)
        begin
            held_obj = '0;
            predicted_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_q.size() == 0)
                begin
                    report($sformatf("result word with nothing pending: hit %0b pair_kind %0d",
                                     m_tdata[0], m_tuser));
                end
                else
                begin
                    want = predicted_q.pop_front();
                    if (m_tdata[0] !== want.hit)
                        report($sformatf("hit is %0b, predicted %0b (pair_kind %0d)",
                                         m_tdata[0], want.hit, want.pair_kind));
                    if (m_tuser !== want.pair_kind)
                        report($sformatf("pair_kind is %0d, predicted %0d",
                                         m_tuser, want.pair_kind));
                end
            end
            if (s_tvalid && s_tready)
            begin
                word.present = s_tuser[USER_PRESENT];
                word.is_box  = s_tuser[USER_IS_BOX];
                {word.scl, word.ext, word.pos} = s_tdata[IN_FIELDS_W-1:0];
                if (s_tuser[USER_KIND])
                    predicted_q.push_back(predict_overlap(held_obj, word));
                else
                    held_obj = word;
            end
            outstanding <= predicted_q.size();
        end
    end

endmodule

FILE: tb/tb_collider_pair_overlap_test_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Collider pair overlap test core testbench
// Sends a directed set of store and test words covering boundaries, missing
// colliders and field extremes, then random object pairs, mostly placed near each
// other, with random idling on both channels. A checker predicts every result.
// ----------------------------------------------------------------------------
module tb_collider_pair_overlap_test_core;
    import cpo_pkg::*;

    localparam bit KIND_STORE   = 1'b0;
    localparam bit KIND_TEST    = 1'b1;
    localparam int RANDOM_ITEMS = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    int mismatches;
    int outstanding;
    int items_sent;
    bit quiet;

    collider_pair_overlap_test_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    overlap_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= quiet || ($urandom_range(0, 99) >= 26);
        end
    end

    function automatic obj_t make_obj(input bit present, input bit is_box,
                                      input int px, input int py, input int pz,
                                      input int ex, input int ey, input int ez,
                                      input int sc);
        obj_t o;
        o.present = present;
        o.is_box  = is_box;
        o.pos[0]  = px[POS_WIDTH-1:0];
        o.pos[1]  = py[POS_WIDTH-1:0];
        o.pos[2]  = pz[POS_WIDTH-1:0];
        o.ext[0]  = ex[EXT_WIDTH-1:0];
        o.ext[1]  = ey[EXT_WIDTH-1:0];
        o.ext[2]  = ez[EXT_WIDTH-1:0];
        for (int i = 0; i < 3; i++)
            o.scl[i] = sc[SCALE_WIDTH-1:0];
        return o;
    endfunction

    // Either anywhere in the field range or within 1024 units of the anchor on each axis.
    function automatic obj_t random_obj(input obj_t anchor, input bit close);
        obj_t o;
        o.present = ($urandom_range(0, 99) >= 8);
        o.is_box  = 1'($urandom_range(0, 1));
        for (int i = 0; i < 3; i++)
        begin
            if (close)
                o.pos[i] = anchor.pos[i] + pos_t'($urandom_range(0, 2048)) - pos_t'(1024);
            else
                o.pos[i] = pos_t'($urandom);
            o.ext[i] = ($urandom_range(0, 3) == 0) ? ext_t'($urandom) :
                                                     ext_t'($urandom_range(0, 1023));
            case ($urandom_range(0, 2))
                0: o.scl[i] = scale_t'(256);
                1: o.scl[i] = scale_t'($urandom);
                default: o.scl[i] = scale_t'($urandom_range(0, 511));
            endcase
        end
        return o;
    endfunction

    task automatic send_word(input bit kind, input obj_t o);
        logic [IN_USER_W-1:0] user;
        user               = '0;
        user[USER_KIND]    = kind;
        user[USER_PRESENT] = o.present;
        user[USER_IS_BOX]  = o.is_box;
        while (!quiet && $urandom_range(0, 99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({o.scl, o.ext, o.pos});
        s_tuser  <= user;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        obj_t anchor;
        int   pick;
        bit   paused;
        items_sent = 0;
        quiet      = 1'b0;
        paused     = 1'b0;
        anchor     = '0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Test before any store, then stores and tests with a missing collider.
        send_word(KIND_TEST,  make_obj(1, 0, 0, 0, 0, 256, 0, 0, 256));
        send_word(KIND_STORE, make_obj(0, 0, 0, 0, 0, 256, 0, 0, 256));
        send_word(KIND_TEST,  make_obj(1, 0, 0, 0, 0, 256, 0, 0, 256));
        send_word(KIND_STORE, make_obj(1, 0, 0, 0, 0, 256, 0, 0, 256));
        send_word(KIND_TEST,  make_obj(0, 0, 0, 0, 0, 256, 0, 0, 256));
        // Sphere pairs on, just past and well inside the touching distance.
        send_word(KIND_TEST,  make_obj(1, 0, 512, 0, 0, 256, 0, 0, 256));
        send_word(KIND_TEST,  make_obj(1, 0, 513, 0, 0, 256, 0, 0, 256));
        send_word(KIND_TEST,  make_obj(1, 0, 200, 200, 200, 256, 0, 0, 256));
        // Held sphere against boxes: touching, apart, and a box of zero size.
        send_word(KIND_TEST,  make_obj(1, 1, 356, 0, 0, 100, 100, 100, 256));
        send_word(KIND_TEST,  make_obj(1, 1, 357, 0, 0, 100, 100, 100, 256));
        send_word(KIND_TEST,  make_obj(1, 1, 0, 0, 0, 0, 0, 0, 0));
        // Box pairs touching on every axis, apart on one, and mirrored.
        send_word(KIND_STORE, make_obj(1, 1, 0, 0, 0, 100, 200, 300, 4095));
        send_word(KIND_TEST,  make_obj(1, 1, 200, 400, 600, 100, 200, 300, 256));
        send_word(KIND_TEST,  make_obj(1, 1, 200, 401, 600, 100, 200, 300, 256));
        send_word(KIND_TEST,  make_obj(1, 1, -200, -400, -600, 100, 200, 300, 256));
        // Held box at full scale against spheres right at its scaled face.
        send_word(KIND_TEST,  make_obj(1, 0, 1700, 0, 0, 101, 0, 0, 0));
        send_word(KIND_TEST,  make_obj(1, 0, 1700, 0, 0, 100, 0, 0, 0));
        // Extreme positions, extents and scales.
        send_word(KIND_STORE, make_obj(1, 0, 8388607, 8388607, 8388607, 65535, 0, 0, 4095));
        send_word(KIND_TEST,  make_obj(1, 0, -8388608, -8388608, -8388608, 65535, 0, 0, 0));
        send_word(KIND_TEST,  make_obj(1, 1, -8388608, -8388608, -8388608,
                                       65535, 65535, 65535, 4095));
        send_word(KIND_STORE, make_obj(1, 1, -8388608, -8388608, -8388608,
                                       65535, 65535, 65535, 4095));
        send_word(KIND_TEST,  make_obj(1, 0, 8388607, 8388607, 8388607, 65535, 0, 0, 4095));
        send_word(KIND_TEST,  make_obj(1, 1, 8388607, 8388607, 8388607,
                                       65535, 65535, 65535, 4095));
        send_word(KIND_TEST,  make_obj(0, 0, -8388608, -8388608, -8388608, 65535, 0, 0, 0));
        drain();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            quiet = (items_sent >= 600 && items_sent < 1000);
            if (!paused && items_sent >= 1500)
            begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                anchor = random_obj(anchor, $urandom_range(0, 3) == 0);
                send_word(KIND_STORE, anchor);
                repeat ($urandom_range(1, 3))
                    send_word(KIND_TEST, random_obj(anchor, $urandom_range(0, 4) != 0));
            end
            else if (pick < 93)
            begin
                send_word(KIND_TEST, random_obj(anchor, 1'b0));
            end
            else
            begin
                send_word(KIND_STORE, random_obj(anchor, 1'b0));
            end
        end
        quiet = 1'b0;
        drain();
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/cpo_pkg.sv
sv/cpo_mul.sv
sv/collider_pair_overlap_test_core.sv
tb/overlap_result_checker.sv
tb/tb_collider_pair_overlap_test_core.sv
